// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL of the audio packet pacer top level.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define AP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define AP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define AP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define AP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/app_pkg.sv -----
// Package for the audio packet pacer: widths, codes, constants, divider types.
// No dependencies.
package app_pkg;

  localparam int PERIOD_MS_DEF        = 5;
  localparam int MAX_PACKET_BYTES_DEF = 4096;

  localparam int FUNC_W     = 2;
  localparam int TIME_W     = 64;
  localparam int OFS_W      = 32;
  localparam int LEN_W      = 13;
  localparam int MS_W       = 3;
  localparam int SR_W       = 19;
  localparam int BPF_W      = 6;
  localparam int SPD_W      = 8;
  localparam int TB_W       = 32;
  localparam int DRIFT_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_DW     = 40;
  localparam int DIV_VW     = 16;

  localparam logic [SR_W-1:0]  SR_RST  = SR_W'(44100);
  localparam logic [BPF_W-1:0] BPF_RST = BPF_W'(4);
  localparam logic [SPD_W-1:0] SPD_RST = SPD_W'(100);
  localparam logic [TB_W-1:0]  TB_RST  = TB_W'(1048576);

  localparam int K_MS_PER_S   = 1000;
  localparam int K_US_PER_S   = 1000000;
  localparam int K_PERCENT    = 100;
  localparam int K_TENTH      = 10;
  localparam int K_ROUND      = 5;
  localparam int K_DRIFT_STEP = 1000;

  localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PAUSE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BPF         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BYTES = 2'd3;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_DW-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/app_in_if.sv -----
// Input channel of the audio packet pacer: command word with timestamp.
// Depends on app_pkg.
interface app_in_if;
  import app_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [TIME_W-1:0] now_us;
  modport source (output valid, func, now_us, input ready);
  modport sink   (input valid, func, now_us, output ready);
endinterface

// ----- rtl/app_out_if.sv -----
// Result channel of the audio packet pacer: segment and timer word.
// Depends on app_pkg.
interface app_out_if;
  import app_pkg::*;
  logic             valid;
  logic             ready;
  logic             send_valid;
  logic [OFS_W-1:0] first_offset;
  logic [LEN_W-1:0] first_length;
  logic [LEN_W-1:0] second_length;
  logic             track_start;
  logic             wrapped;
  logic             timer_arm;
  logic [MS_W-1:0]  next_timer_ms;
  modport source (output valid, send_valid, first_offset, first_length, second_length,
                  track_start, wrapped, timer_arm, next_timer_ms, input ready);
  modport sink   (input valid, send_valid, first_offset, first_length, second_length,
                  track_start, wrapped, timer_arm, next_timer_ms, output ready);
endinterface

// ----- rtl/audio_packet_pacer.sv -----
// Audio packet pacer top level: sequencer, state and output register around app_div.
// A tick runs seven divisions on the shared divider between accept and result
// valid, and one more when drift sets the period. Pause, restart and unused
// commands skip the divider. One word is in work at a time.
// Reset (rst_n, synchronous, active low) loads the register defaults and clears
// read position, timestamp, drift and pause. Depends on app_pkg, app_in_if, app_out_if.
`include "assert_macros.svh"
module audio_packet_pacer #(
  parameter int PERIOD_MS        = app_pkg::PERIOD_MS_DEF,
  parameter int MAX_PACKET_BYTES = app_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [app_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [app_pkg::CFG_DATA_W-1:0] cfg_wdata,
  app_in_if.sink                         in_ch,
  app_out_if.source                      out_ch
);
  import app_pkg::*;

  localparam int NORM_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int PER_W  = $clog2(PERIOD_MS + 2);
  localparam int PROD_W = SR_W + BPF_W;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_GO   = 8'b0000_0100,
    S_WAIT = 8'b0000_1000,
    S_SEG  = 8'b0001_0000,
    S_TIME = 8'b0010_0000,
    S_CHK  = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  typedef enum logic [2:0] {
    OP_NORM, OP_RDIV, OP_FRAMES, OP_TIME, OP_ROUND, OP_SPEED, OP_WHOLE, OP_DRIFT
  } op_t;

  typedef struct packed {
    logic             send_valid;
    logic [OFS_W-1:0] first_offset;
    logic [LEN_W-1:0] first_length;
    logic [LEN_W-1:0] second_length;
    logic             track_start;
    logic             wrapped;
    logic             timer_arm;
    logic [MS_W-1:0]  next_timer_ms;
  } res_t;

  logic [SR_W-1:0]  sr_r;
  logic [BPF_W-1:0] bpf_r;
  logic [SPD_W-1:0] spd_r;
  logic [TB_W-1:0]  tb_r;

  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                paused_r, paused_nxt;
  logic [OFS_W-1:0]    bi_r, bi_nxt;
  logic [TIME_W-1:0]   last_r, last_nxt;
  logic [DRIFT_W-1:0]  drift_r, drift_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [NORM_W-1:0]   norm_r, norm_nxt;
  logic [DIV_VW-1:0]   rdiv_r, rdiv_nxt;
  logic [NORM_W-1:0]   q1_r, q1_nxt;
  logic [DIV_DW-1:0]   t0_r, t0_nxt;
  logic [DRIFT_W-1:0]  pt_r, pt_nxt;
  logic [NORM_W-1:0]   bcap_r, bcap_nxt;
  logic [NORM_W-1:0]   pb_r, pb_nxt;
  logic                upd_r, upd_nxt;
  logic [DRIFT_W-1:0]  elapsed_r, elapsed_nxt;
  res_t                res_r, res_nxt;
  res_t                out_r, out_nxt;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic [BPF_W-1:0]    bpf_eff;
  logic [DRIFT_W-1:0]  mag;
  logic [TB_W:0]       seg_sum;
  logic                seg_fit;
  logic [TB_W-1:0]     seg_first;
  logic [TB_W:0]       seg_rem;
  logic [DIV_DW-1:0]   quo;

  app_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign bpf_eff   = (bpf_r == '0) ? BPF_W'(1) : bpf_r;
  assign mag       = '0 - drift_r;
  assign quo       = div_rsp.quotient;
  assign seg_sum   = {1'b0, bi_r} + (TB_W + 1)'(pb_r);
  assign seg_fit   = seg_sum <= {1'b0, tb_r};
  assign seg_first = (bi_r < tb_r) ? (tb_r - bi_r) : '0;
  assign seg_rem   = (TB_W + 1)'(pb_r) - {1'b0, seg_first};

  always_comb begin
    div_req.start    = state_r == S_GO;
    div_req.dividend = '0;
    div_req.divisor  = DIV_VW'(1);
    case (op_r)
      OP_NORM: begin
        div_req.dividend = DIV_DW'(prod_r) * DIV_DW'(PERIOD_MS);
        div_req.divisor  = DIV_VW'(K_MS_PER_S);
      end
      OP_RDIV: begin
        div_req.dividend = DIV_DW'(sr_r);
        div_req.divisor  = DIV_VW'(K_TENTH);
      end
      OP_FRAMES: begin
        div_req.dividend = DIV_DW'(norm_r);
        div_req.divisor  = DIV_VW'(bpf_eff);
      end
      OP_TIME: begin
        div_req.dividend = DIV_DW'(q1_r) * DIV_DW'(K_US_PER_S);
        div_req.divisor  = rdiv_r;
      end
      OP_ROUND: begin
        div_req.dividend = t0_r + DIV_DW'(K_ROUND);
        div_req.divisor  = DIV_VW'(K_TENTH);
      end
      OP_SPEED: begin
        div_req.dividend = DIV_DW'(norm_r) * DIV_DW'(spd_r);
        div_req.divisor  = DIV_VW'(K_PERCENT);
      end
      OP_WHOLE: begin
        div_req.dividend = DIV_DW'(bcap_r);
        div_req.divisor  = DIV_VW'(bpf_eff);
      end
      OP_DRIFT: begin
        div_req.dividend = DIV_DW'(mag);
        div_req.divisor  = DIV_VW'(K_DRIFT_STEP);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    paused_nxt    = paused_r;
    bi_nxt        = bi_r;
    last_nxt      = last_r;
    drift_nxt     = drift_r;
    now_nxt       = now_r;
    prod_nxt      = prod_r;
    norm_nxt      = norm_r;
    rdiv_nxt      = rdiv_r;
    q1_nxt        = q1_r;
    t0_nxt        = t0_r;
    pt_nxt        = pt_r;
    bcap_nxt      = bcap_r;
    pb_nxt        = pb_r;
    upd_nxt       = upd_r;
    elapsed_nxt   = elapsed_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          res_nxt   = '0;
          state_nxt = S_EMIT;
          case (in_ch.func)
            FUNC_TICK: begin
              if (!paused_r) begin
                now_nxt   = in_ch.now_us;
                op_nxt    = OP_NORM;
                state_nxt = S_MUL;
              end
            end
            FUNC_PAUSE: begin
              if (paused_r) begin
                paused_nxt            = 1'b0;
                last_nxt              = '0;
                drift_nxt             = '0;
                res_nxt.timer_arm     = 1'b1;
                res_nxt.next_timer_ms = MS_W'(PERIOD_MS);
              end else begin
                paused_nxt = 1'b1;
              end
            end
            FUNC_RESTART: bi_nxt = '0;
            default: ;
          endcase
        end
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(sr_r) * PROD_W'(bpf_eff);
        state_nxt = S_GO;
      end
      S_GO: state_nxt = S_WAIT;
      S_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = S_GO;
          case (op_r)
            OP_NORM: begin
              norm_nxt = (quo > DIV_DW'(MAX_PACKET_BYTES)) ? NORM_W'(MAX_PACKET_BYTES)
                                                           : quo[NORM_W-1:0];
              op_nxt   = OP_RDIV;
            end
            OP_RDIV: begin
              rdiv_nxt = (quo == '0) ? DIV_VW'(1) : quo[DIV_VW-1:0];
              op_nxt   = OP_FRAMES;
            end
            OP_FRAMES: begin
              q1_nxt = quo[NORM_W-1:0];
              op_nxt = OP_TIME;
            end
            OP_TIME: begin
              t0_nxt = quo;
              op_nxt = OP_ROUND;
            end
            OP_ROUND: begin
              pt_nxt = quo[DRIFT_W-1:0];
              op_nxt = OP_SPEED;
            end
            OP_SPEED: begin
              bcap_nxt = (quo > DIV_DW'(MAX_PACKET_BYTES)) ? NORM_W'(MAX_PACKET_BYTES)
                                                           : quo[NORM_W-1:0];
              op_nxt   = OP_WHOLE;
            end
            OP_WHOLE: begin
              pb_nxt    = NORM_W'(quo[NORM_W-1:0] * NORM_W'(bpf_eff));
              state_nxt = S_SEG;
            end
            OP_DRIFT: begin
              if (quo > DIV_DW'(PERIOD_MS - 1)) begin
                res_nxt.next_timer_ms = MS_W'(1);
              end else begin
                res_nxt.next_timer_ms = MS_W'(PER_W'(PERIOD_MS) - quo[PER_W-1:0]);
              end
              state_nxt = S_EMIT;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SEG: begin
        res_nxt.send_valid   = 1'b1;
        res_nxt.first_offset = bi_r;
        res_nxt.track_start  = bi_r == '0;
        if (seg_fit) begin
          res_nxt.first_length = LEN_W'(pb_r);
          bi_nxt               = seg_sum[TB_W-1:0];
        end else begin
          res_nxt.first_length  = seg_first[LEN_W-1:0];
          res_nxt.second_length = seg_rem[LEN_W-1:0];
          res_nxt.wrapped       = 1'b1;
          bi_nxt                = seg_rem[TB_W-1:0];
        end
        upd_nxt     = (last_r != '0) && (last_r < now_r);
        elapsed_nxt = DRIFT_W'(now_r - last_r);
        last_nxt    = now_r;
        state_nxt   = S_TIME;
      end
      S_TIME: begin
        if (upd_r) begin
          drift_nxt = drift_r - (elapsed_r - pt_r);
        end
        state_nxt = S_CHK;
      end
      S_CHK: begin
        res_nxt.timer_arm     = 1'b1;
        res_nxt.next_timer_ms = MS_W'(PERIOD_MS);
        state_nxt             = S_EMIT;
        if (upd_r) begin
          if (drift_r[DRIFT_W-1]) begin
            if (mag > DRIFT_W'(K_DRIFT_STEP)) begin
              op_nxt    = OP_DRIFT;
              state_nxt = S_GO;
            end
          end else if (drift_r > DRIFT_W'(K_DRIFT_STEP)) begin
            res_nxt.next_timer_ms = MS_W'(PERIOD_MS + 1);
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_r  <= SR_RST;
      bpf_r <= BPF_RST;
      spd_r <= SPD_RST;
      tb_r  <= TB_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SAMPLE_RATE: sr_r  <= cfg_wdata[SR_W-1:0];
        CFG_BPF:         bpf_r <= cfg_wdata[BPF_W-1:0];
        CFG_SPEED:       spd_r <= cfg_wdata[SPD_W-1:0];
        CFG_TOTAL_BYTES: tb_r  <= cfg_wdata[TB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      paused_r    <= 1'b0;
      bi_r        <= '0;
      last_r      <= '0;
      drift_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      paused_r    <= paused_nxt;
      bi_r        <= bi_nxt;
      last_r      <= last_nxt;
      drift_r     <= drift_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    now_r     <= now_nxt;
    prod_r    <= prod_nxt;
    norm_r    <= norm_nxt;
    rdiv_r    <= rdiv_nxt;
    q1_r      <= q1_nxt;
    t0_r      <= t0_nxt;
    pt_r      <= pt_nxt;
    bcap_r    <= bcap_nxt;
    pb_r      <= pb_nxt;
    upd_r     <= upd_nxt;
    elapsed_r <= elapsed_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign in_ch.ready          = state_r == S_IDLE;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.send_valid    = out_r.send_valid;
  assign out_ch.first_offset  = out_r.first_offset;
  assign out_ch.first_length  = out_r.first_length;
  assign out_ch.second_length = out_r.second_length;
  assign out_ch.track_start   = out_r.track_start;
  assign out_ch.wrapped       = out_r.wrapped;
  assign out_ch.timer_arm     = out_r.timer_arm;
  assign out_ch.next_timer_ms = out_r.next_timer_ms;

  `AP_ASSERT_IMPL(a_send_arms_timer, clk, rst_n, out_valid_r && out_r.send_valid, out_r.timer_arm)
  `AP_ASSERT_IMPL(a_second_needs_wrap, clk, rst_n, out_valid_r && !out_r.wrapped, out_r.second_length == '0)
  `AP_ASSERT_NEXT(a_one_word_in_work, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  `AP_ASSERT_IMPL(a_div_start_idle, clk, rst_n, div_req.start, !div_rsp.busy)

endmodule

// ----- rtl/app_div.sv -----
// Shared iterative restoring divider, two quotient bits per cycle.
// Depends on app_pkg (widths, request and response structs).
module app_div (
  input  logic              clk,
  input  logic              rst_n,
  input  app_pkg::div_req_t req,
  output app_pkg::div_rsp_t rsp
);
  import app_pkg::*;

  localparam int STEPS = DIV_DW / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIV_DW-1:0] quo_r, quo_nxt;
  logic [DIV_VW-1:0] rem_r, rem_nxt;
  logic [DIV_VW-1:0] dsr_r, dsr_nxt;

  logic [DIV_VW:0]   t1, t2;
  logic [DIV_VW-1:0] r1, r2;
  logic              b1, b2;

  always_comb begin
    t1 = {rem_r, quo_r[DIV_DW-1]};
    b1 = t1 >= {1'b0, dsr_r};
    r1 = b1 ? DIV_VW'(t1 - {1'b0, dsr_r}) : t1[DIV_VW-1:0];
    t2 = {r1, quo_r[DIV_DW-2]};
    b2 = t2 >= {1'b0, dsr_r};
    r2 = b2 ? DIV_VW'(t2 - {1'b0, dsr_r}) : t2[DIV_VW-1:0];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_DW-3:0], b1, b2};
      rem_nxt = r2;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
